>>> rtl/core/crc8fr_pkg.sv
// ============================================================================
// crc8fr_pkg
// Shared types and codes for the CRC-8 length-prefixed frame receiver.
// ============================================================================
package crc8fr_pkg;

    // one received or released byte
    typedef logic [7:0] byte_t;

    // payload length as carried on the result channel
    localparam int LEN_W = 7;
    typedef logic [LEN_W-1:0] len_t;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_START_MARKER = 2'd0;
    localparam cfg_index_t CFG_END_MARKER   = 2'd1;
    localparam cfg_index_t CFG_CRC_POLY     = 2'd2;
    localparam cfg_index_t CFG_CRC_INIT     = 2'd3;

    // configuration reset values
    localparam byte_t START_MARKER_RST = 8'h02;
    localparam byte_t END_MARKER_RST   = 8'h03;
    localparam byte_t CRC_POLY_RST     = 8'h07;
    localparam byte_t CRC_INIT_RST     = 8'h00;

    // result event kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_NONE   = 2'd0;
    localparam kind_t KIND_DATA   = 2'd1;
    localparam kind_t KIND_REJECT = 2'd2;

    // rejection reasons
    typedef logic [1:0] reason_t;
    localparam reason_t RSN_TOO_LONG    = 2'd0;
    localparam reason_t RSN_ZERO_LEN    = 2'd1;
    localparam reason_t RSN_CRC_BAD     = 2'd2;
    localparam reason_t RSN_MISSING_END = 2'd3;

endpackage

>>> rtl/core/crc8_frame_receiver_unit.sv
// ============================================================================
// crc8_frame_receiver_unit
// Length-prefixed frame receiver with CRC-8 check and buffered payload release.
// ============================================================================
//
//  Channel  Dir  Handshake          Contents
//  s_       in   s_tvalid/s_tready  rx_byte in s_tdata
//  m_       out  m_tvalid/m_tready  event kind in m_tuser, data/reason/length
//                                   in m_tdata, last result of a byte in m_tlast
//  cfg_     in   cfg_valid/cfg_ready register index and 8-bit value
//
//  Every received byte gives exactly one result, except the closing end byte
//  of a good frame, which releases the buffered payload: each payload byte is
//  read from the buffer in ST_READ and put in the result register in ST_LOAD
//  when that is free. Other bytes go in whenever the result register is free.
//  Reset is synchronous on aresetn low; the buffer content is not cleared.
//  A stalled m_ side holds the result register and blocks s_ input.
// ============================================================================
module crc8_frame_receiver_unit
    import crc8fr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] data_byte, [9:8] reject_reason,
                                    // [16:10] frame_length, [23:17] zero
    output logic [1:0]  m_tuser,    // [1:0] event_kind
    output logic        m_tlast,    // last_of_run

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  byte_t       cfg_data
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_LEN,
        ST_DATA,
        ST_CRC,
        ST_END,
        ST_READ,
        ST_LOAD
    } state_t;

    state_t  state_reg;
    byte_t   start_marker_reg;
    byte_t   end_marker_reg;
    byte_t   crc_poly_reg;
    byte_t   crc_init_reg;
    len_t    expected_reg;
    len_t    received_reg;
    len_t    rd_cnt_reg;
    byte_t   crc_reg;

    logic    m_valid_reg;
    kind_t   m_kind_reg;
    byte_t   m_data_reg;
    reason_t m_reason_reg;
    len_t    m_len_reg;
    logic    m_last_reg;

    logic    s_accept;
    logic    out_free;
    byte_t   rx_byte;
    byte_t   crc_upd;
    len_t    received_inc;
    byte_t   ram_rdata;
    logic    ram_wr_en;
    logic    ram_rd_en;

    assign rx_byte      = s_tdata;
    assign out_free     = !m_valid_reg || m_tready;
    assign s_tready     = (state_reg != ST_READ) && (state_reg != ST_LOAD) && out_free;
    assign s_accept     = s_tvalid && s_tready;
    assign cfg_ready    = 1'b1;
    assign received_inc = received_reg + len_t'(1);

    // buffer access: fill during payload, read back during release
    assign ram_wr_en = s_accept && (state_reg == ST_DATA);
    assign ram_rd_en = (state_reg == ST_READ);

    crc8fr_payload_ram #(
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (received_reg[AW-1:0]),
        .wr_data (rx_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_cnt_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    crc8fr_crc_unit u_crc (
        .crc_in  (crc_reg),
        .data_in (rx_byte),
        .poly    (crc_poly_reg),
        .crc_out (crc_upd)
    );

    // frame state machine, configuration and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_HUNT;
            start_marker_reg <= START_MARKER_RST;
            end_marker_reg   <= END_MARKER_RST;
            crc_poly_reg     <= CRC_POLY_RST;
            crc_init_reg     <= CRC_INIT_RST;
            expected_reg     <= '0;
            received_reg     <= '0;
            rd_cnt_reg       <= '0;
            crc_reg          <= CRC_INIT_RST;
            m_valid_reg      <= 1'b0;
            m_kind_reg       <= KIND_NONE;
            m_data_reg       <= '0;
            m_reason_reg     <= RSN_TOO_LONG;
            m_len_reg        <= '0;
            m_last_reg       <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_START_MARKER: start_marker_reg <= cfg_data;
                    CFG_END_MARKER:   end_marker_reg   <= cfg_data;
                    CFG_CRC_POLY:     crc_poly_reg     <= cfg_data;
                    CFG_CRC_INIT:     crc_init_reg     <= cfg_data;
                    default: ;
                endcase
            end

            // result taken downstream
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            if (s_accept) begin
                // default: one no-event result
                m_valid_reg  <= 1'b1;
                m_kind_reg   <= KIND_NONE;
                m_data_reg   <= '0;
                m_reason_reg <= RSN_TOO_LONG;
                m_len_reg    <= '0;
                m_last_reg   <= 1'b1;
                case (state_reg)
                    ST_LEN: begin
                        if ({1'b0, rx_byte} > 9'(MAX_PAYLOAD)) begin
                            m_kind_reg   <= KIND_REJECT;
                            m_reason_reg <= RSN_TOO_LONG;
                            expected_reg <= '0;
                            received_reg <= '0;
                            state_reg    <= ST_HUNT;
                        end else if (rx_byte == 8'd0) begin
                            m_kind_reg   <= KIND_REJECT;
                            m_reason_reg <= RSN_ZERO_LEN;
                            expected_reg <= '0;
                            received_reg <= '0;
                            state_reg    <= ST_HUNT;
                        end else begin
                            expected_reg <= rx_byte[LEN_W-1:0];
                            received_reg <= '0;
                            m_len_reg    <= rx_byte[LEN_W-1:0];
                            state_reg    <= ST_DATA;
                        end
                    end
                    ST_DATA: begin
                        received_reg <= received_inc;
                        crc_reg      <= crc_upd;
                        m_len_reg    <= expected_reg;
                        if (received_inc >= expected_reg) begin
                            state_reg <= ST_CRC;
                        end
                    end
                    ST_CRC: begin
                        m_len_reg <= expected_reg;
                        if (rx_byte != crc_reg) begin
                            m_kind_reg   <= KIND_REJECT;
                            m_reason_reg <= RSN_CRC_BAD;
                            expected_reg <= '0;
                            received_reg <= '0;
                            state_reg    <= ST_HUNT;
                        end else begin
                            state_reg <= ST_END;
                        end
                    end
                    ST_END: begin
                        if (rx_byte != end_marker_reg) begin
                            m_kind_reg   <= KIND_REJECT;
                            m_reason_reg <= RSN_MISSING_END;
                            m_len_reg    <= expected_reg;
                            expected_reg <= '0;
                            received_reg <= '0;
                            state_reg    <= ST_HUNT;
                        end else begin
                            // good frame: release the buffer instead
                            m_valid_reg <= 1'b0;
                            rd_cnt_reg  <= '0;
                            state_reg   <= ST_READ;
                        end
                    end
                    default: begin
                        if (rx_byte == start_marker_reg) begin
                            crc_reg   <= crc_init_reg;
                            state_reg <= ST_LEN;
                        end
                    end
                endcase
            end else begin
                case (state_reg)
                    // buffer read issued, data valid next cycle
                    ST_READ: state_reg <= ST_LOAD;
                    ST_LOAD: begin
                        if (out_free) begin
                            m_valid_reg  <= 1'b1;
                            m_kind_reg   <= KIND_DATA;
                            m_data_reg   <= ram_rdata;
                            m_reason_reg <= RSN_TOO_LONG;
                            m_len_reg    <= expected_reg;
                            if (rd_cnt_reg == expected_reg - len_t'(1)) begin
                                m_last_reg   <= 1'b1;
                                expected_reg <= '0;
                                received_reg <= '0;
                                state_reg    <= ST_HUNT;
                            end else begin
                                m_last_reg <= 1'b0;
                                rd_cnt_reg <= rd_cnt_reg + len_t'(1);
                                state_reg  <= ST_READ;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // result channel
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {7'd0, m_len_reg, m_reason_reg, m_data_reg};
    assign m_tlast  = m_last_reg;

endmodule

>>> rtl/core/crc8fr_crc_unit.sv
// ============================================================================
// crc8fr_crc_unit
// One-byte CRC-8 update, MSB first, programmable polynomial (implicit x^8).
// ============================================================================
module crc8fr_crc_unit
    import crc8fr_pkg::*;
(
    input  byte_t crc_in,
    input  byte_t data_in,
    input  byte_t poly,
    output byte_t crc_out
);

    // eight shift/xor steps over the byte
    always_comb begin
        byte_t v;
        v = crc_in ^ data_in;
        for (int i = 0; i < 8; i++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ poly;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        crc_out = v;
    end

endmodule

>>> rtl/core/crc8fr_payload_ram.sv
// ============================================================================
// crc8fr_payload_ram
// Payload buffer: one write port, one read port, registered read data.
// ============================================================================
module crc8fr_payload_ram
    import crc8fr_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  byte_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output byte_t         rd_data
);

    byte_t mem [DEPTH];
    byte_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the CRC-8 length-prefixed frame receiver.
//
// A queue of received bytes feeds a clocked stream driver. Each byte that the
// block accepts also goes through a local deframer model, which queues the
// results the block should produce. A clocked monitor takes every result
// transfer and checks each field against the oldest queued result. The run
// steps through several marker and CRC settings, the extremes among them.
// Register writes happen only while the block is idle. Traffic is a short
// directed set followed by random frames: mostly good ones, plus bad lengths,
// bad CRC bytes, bad end bytes, cut-off frames and stray bytes. Both sides
// stall at random, except for one phase that runs with no stalls at all.
// ============================================================================
module tb_top;
    import crc8fr_pkg::*;

    localparam int MAX_PAYLOAD   = 64;
    localparam int IDLE_PCT      = 32;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_MAX    = 10;

    localparam reason_t NO_REASON = '0;

    typedef enum logic [2:0] {
        RX_HUNT,
        RX_LEN,
        RX_PAYLOAD,
        RX_CRC,
        RX_CLOSE
    } rx_phase_t;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_CRC,
        FRAME_BAD_END,
        FRAME_CUT
    } frame_fault_t;

    typedef struct {
        kind_t   kind;
        byte_t   data;
        reason_t reason;
        len_t    len;
        logic    last;
    } rx_result_t;

    // DUT ports
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;  // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;            // [7:0] data_byte, [9:8] reject_reason,
                                     // [16:10] frame_length, [23:17] zero
    logic [1:0]  m_tuser;            // [1:0] event_kind
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_START_MARKER;
    byte_t       cfg_data  = 8'h00;

    // register copies, shared by the stimulus builder and the deframer model
    byte_t start_marker_q = START_MARKER_RST;
    byte_t end_marker_q   = END_MARKER_RST;
    byte_t crc_poly_q     = CRC_POLY_RST;
    byte_t crc_init_q     = CRC_INIT_RST;

    // deframer model state
    rx_phase_t rx_phase   = RX_HUNT;
    len_t      want_count = '0;
    len_t      got_count  = '0;
    byte_t     crc_reg    = CRC_INIT_RST;
    byte_t     payload_mem [MAX_PAYLOAD];

    byte_t      rx_pending[$];
    rx_result_t expected_results[$];
    int         mismatch_count = 0;
    int         stall_cycles   = 0;
    bit         steady         = 1'b0;

    crc8_frame_receiver_unit #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // MSB-first CRC-8 over one byte, implicit x^8
    function automatic byte_t crc8_next(byte_t r, byte_t b, byte_t poly);
        byte_t v;
        v = r ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7]) begin
                v = (v << 1) ^ poly;
            end else begin
                v = v << 1;
            end
        end
        return v;
    endfunction

    function automatic bit idle_roll();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    task automatic expect_result(kind_t k, byte_t d, reason_t r, len_t l, logic last);
        rx_result_t res;
        res.kind   = k;
        res.data   = d;
        res.reason = r;
        res.len    = l;
        res.last   = last;
        expected_results.push_back(res);
    endtask

    task automatic back_to_hunt();
        rx_phase   = RX_HUNT;
        want_count = '0;
        got_count  = '0;
        crc_reg    = crc_init_q;
    endtask

    // deframer model: one accepted byte in, its results queued
    task automatic deframe_predict(byte_t b);
        len_t l;
        case (rx_phase)
            RX_LEN: begin
                if (b > MAX_PAYLOAD) begin
                    back_to_hunt();
                    expect_result(KIND_REJECT, 8'h00, RSN_TOO_LONG, '0, 1'b1);
                end else if (b == 8'h00) begin
                    back_to_hunt();
                    expect_result(KIND_REJECT, 8'h00, RSN_ZERO_LEN, '0, 1'b1);
                end else begin
                    want_count = len_t'(b);
                    got_count  = '0;
                    rx_phase   = RX_PAYLOAD;
                    expect_result(KIND_NONE, 8'h00, NO_REASON, want_count, 1'b1);
                end
            end
            RX_PAYLOAD: begin
                if (got_count < want_count) begin
                    payload_mem[got_count] = b;
                    got_count = got_count + 1'b1;
                    crc_reg   = crc8_next(crc_reg, b, crc_poly_q);
                end
                if (got_count >= want_count) begin
                    rx_phase = RX_CRC;
                end
                expect_result(KIND_NONE, 8'h00, NO_REASON, want_count, 1'b1);
            end
            RX_CRC: begin
                if (b != crc_reg) begin
                    l = want_count;
                    back_to_hunt();
                    expect_result(KIND_REJECT, 8'h00, RSN_CRC_BAD, l, 1'b1);
                end else begin
                    rx_phase = RX_CLOSE;
                    expect_result(KIND_NONE, 8'h00, NO_REASON, want_count, 1'b1);
                end
            end
            RX_CLOSE: begin
                l = want_count;
                if (b != end_marker_q) begin
                    back_to_hunt();
                    expect_result(KIND_REJECT, 8'h00, RSN_MISSING_END, l, 1'b1);
                end else begin
                    // good frame: release the buffered payload as one run
                    for (int i = 0; i < got_count; i++) begin
                        expect_result(KIND_DATA, payload_mem[i], NO_REASON, l,
                                      i == got_count - 1);
                    end
                    back_to_hunt();
                end
            end
            default: begin
                back_to_hunt();
                if (b == start_marker_q) begin
                    rx_phase = RX_LEN;
                end
                expect_result(KIND_NONE, 8'h00, NO_REASON, '0, 1'b1);
            end
        endcase
    endtask

    task automatic note_mismatch(string field, int want, int got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, field, want, got);
        end
    endtask

    // compare one result transfer with the oldest queued result
    task automatic check_result();
        rx_result_t exp_res;
        if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
                $display("%0t: result with none queued, tuser 0x%0h tdata 0x%0h tlast %0b",
                         $time, m_tuser, m_tdata, m_tlast);
            end
        end else begin
            exp_res = expected_results.pop_front();
            if (m_tuser != exp_res.kind)
                note_mismatch("event_kind", exp_res.kind, m_tuser);
            if (m_tdata[7:0] != exp_res.data)
                note_mismatch("data_byte", exp_res.data, m_tdata[7:0]);
            if (m_tdata[9:8] != exp_res.reason)
                note_mismatch("reject_reason", exp_res.reason, m_tdata[9:8]);
            if (m_tdata[16:10] != exp_res.len)
                note_mismatch("frame_length", exp_res.len, m_tdata[16:10]);
            if (m_tdata[23:17] != '0)
                note_mismatch("tdata pad", 0, m_tdata[23:17]);
            if (m_tlast != exp_res.last)
                note_mismatch("last_of_run", exp_res.last, m_tlast);
        end
    endtask

    // stimulus builders
    task automatic push_frame(int len, frame_fault_t fault);
        byte_t crc;
        byte_t b;
        int    keep;
        crc  = crc_init_q;
        keep = (fault == FRAME_CUT) ? $urandom_range(len - 1, 0) : len;
        rx_pending.push_back(start_marker_q);
        rx_pending.push_back(byte_t'(len));
        for (int i = 0; i < keep; i++) begin
            b   = byte_t'($urandom);
            crc = crc8_next(crc, b, crc_poly_q);
            rx_pending.push_back(b);
        end
        if (fault == FRAME_CUT) return;
        if (fault == FRAME_BAD_CRC) crc = crc ^ byte_t'($urandom_range(255, 1));
        rx_pending.push_back(crc);
        if (fault == FRAME_BAD_END) begin
            rx_pending.push_back(end_marker_q ^ byte_t'($urandom_range(255, 1)));
        end else begin
            rx_pending.push_back(end_marker_q);
        end
    endtask

    task automatic push_bad_length(byte_t len_byte);
        rx_pending.push_back(start_marker_q);
        rx_pending.push_back(len_byte);
    endtask

    task automatic random_traffic(int budget);
        int goal;
        int pick;
        int len;
        goal = rx_pending.size() + budget;
        while (rx_pending.size() < goal) begin
            pick = $urandom_range(99);
            len  = ($urandom_range(9) == 0) ? $urandom_range(MAX_PAYLOAD, 9)
                                            : $urandom_range(6, 1);
            if (pick < 68) begin
                push_frame(len, FRAME_GOOD);
            end else if (pick < 76) begin
                push_frame(len, FRAME_BAD_CRC);
            end else if (pick < 83) begin
                push_frame(len, FRAME_BAD_END);
            end else if (pick < 89) begin
                push_bad_length($urandom_range(1) ? 8'h00
                                : byte_t'($urandom_range(255, MAX_PAYLOAD + 1)));
            end else if (pick < 94) begin
                push_frame(len, FRAME_CUT);
            end else begin
                repeat ($urandom_range(3, 1)) rx_pending.push_back(byte_t'($urandom));
            end
        end
    endtask

    // hold off until every queued byte went in and every result came out
    task automatic drain();
        while (!(rx_pending.size() == 0 && !s_tvalid && expected_results.size() == 0))
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, byte_t val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_START_MARKER: start_marker_q = val;
            CFG_END_MARKER:   end_marker_q   = val;
            CFG_CRC_POLY:     crc_poly_q     = val;
            CFG_CRC_INIT:     crc_init_q     = val;
            default: ;
        endcase
    endtask

    task automatic set_config(byte_t start_m, byte_t end_m, byte_t poly, byte_t init);
        write_reg(CFG_START_MARKER, start_m);
        write_reg(CFG_END_MARKER, end_m);
        write_reg(CFG_CRC_POLY, poly);
        write_reg(CFG_CRC_INIT, init);
    endtask

    // stream driver: one byte per transfer, random gaps between transfers
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
        end else begin
            if (s_tvalid && s_tready) deframe_predict(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (rx_pending.size() != 0 && !idle_roll()) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= rx_pending.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !idle_roll();
            if (m_tvalid && m_tready) check_result();
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer in %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // test sequence
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset settings: byte extremes, length limits, each rejection
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'hFF);
        push_frame(1, FRAME_GOOD);
        push_bad_length(8'h00);
        push_bad_length(byte_t'(MAX_PAYLOAD + 1));
        push_bad_length(8'hFF);
        push_frame(2, FRAME_BAD_CRC);
        push_frame(1, FRAME_BAD_END);
        drain();

        // all-ones end marker, polynomial and preset, zero start marker
        set_config(8'h00, 8'hFF, 8'hFF, 8'hFF);
        random_traffic(85);
        drain();

        // all-zeros extremes, swapped markers
        set_config(8'hFF, 8'h00, 8'h00, 8'h00);
        random_traffic(85);
        drain();

        // random settings, no stalls on either side
        steady = 1'b1;
        set_config(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
                   byte_t'($urandom));
        random_traffic(75);
        drain();
        steady = 1'b0;

        // default markers, random preset, full-size frame, pause mid-phase
        set_config(START_MARKER_RST, END_MARKER_RST, CRC_POLY_RST, byte_t'($urandom));
        push_frame(MAX_PAYLOAD, FRAME_GOOD);
        random_traffic(45);
        drain();
        random_traffic(45);
        drain();

        if (expected_results.size() != 0) begin
            note_mismatch("results left over", 0, expected_results.size());
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/crc8fr_pkg.sv
rtl/core/crc8fr_crc_unit.sv
rtl/core/crc8fr_payload_ram.sv
rtl/core/crc8_frame_receiver_unit.sv
test/tb_top.sv
